>>> hdl/tbgr_pkg.sv
// Shared types, constants and helpers for the throttle bar graph renderer.
// No dependencies; every other file of the block refers to this package.
package tbgr_pkg;

    localparam int STRIP_LEDS = 32;
    localparam int CNT_W      = $clog2(STRIP_LEDS + 1);
    localparam int IDX_W      = 5;
    localparam int SAMPLE_W   = 12;
    localparam int LEN_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_VALUE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FULL_VALUE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER   = CFG_IDX_W'(4);

    // fill modes
    localparam logic [1:0] FILL_BOTTOM = 2'd0;
    localparam logic [1:0] FILL_TOP    = 2'd1;
    localparam logic [1:0] FILL_MIDDLE = 2'd2;

    // color orders
    localparam logic [2:0] ORDER_RGB = 3'd0;
    localparam logic [2:0] ORDER_RBG = 3'd1;
    localparam logic [2:0] ORDER_GRB = 3'd2;
    localparam logic [2:0] ORDER_GBR = 3'd3;
    localparam logic [2:0] ORDER_BRG = 3'd4;
    localparam logic [2:0] ORDER_BGR = 3'd5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] center_value;
        logic [SAMPLE_W-1:0] full_value;
        logic [LEN_W-1:0]    strip_length;
        logic [1:0]          fill_mode;
        logic [2:0]          byte_order;
    } cfg_t;

    // per-frame parameters handed from the arithmetic pipe to the emitter
    typedef struct packed {
        logic                black;
        logic                brake;
        logic [SAMPLE_W-1:0] fulls;
        logic [BYTE_W-1:0]   part;
    } item_t;

    // clamp the strip length into 1..STRIP_LEDS
    function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        int l;
        l = int'(len);
        if (l == 0)
        begin
            l = 1;
        end
        if (l > STRIP_LEDS)
        begin
            l = STRIP_LEDS;
        end
        return CNT_W'(l);
    endfunction

endpackage

>>> hdl/tbgr_stream_if.sv
// Valid/ready stream interfaces for throttle samples and LED colors.
// Depends on tbgr_pkg for field widths.
interface tbgr_in_if;
    logic                          valid;
    logic                          ready;
    logic [tbgr_pkg::SAMPLE_W-1:0] throttle_sample;
    logic                          system_on;
    logic                          bar_allowed;

    modport source (output valid, output throttle_sample, output system_on,
                    output bar_allowed, input ready);
    modport sink   (input valid, input throttle_sample, input system_on,
                    input bar_allowed, output ready);
endinterface

interface tbgr_out_if;
    logic                        valid;
    logic                        ready;
    logic [tbgr_pkg::IDX_W-1:0]  led_index;
    logic [tbgr_pkg::BYTE_W-1:0] first_byte;
    logic [tbgr_pkg::BYTE_W-1:0] second_byte;
    logic [tbgr_pkg::BYTE_W-1:0] third_byte;
    logic                        frame_end;

    modport source (output valid, output led_index, output first_byte,
                    output second_byte, output third_byte, output frame_end,
                    input ready);
    modport sink   (input valid, input led_index, input first_byte,
                    input second_byte, input third_byte, input frame_end,
                    output ready);
endinterface

>>> hdl/tbgr_calc_pipe.sv
// Ten-stage arithmetic pipe: step, full steps, remainder and partial level.
// Depends on tbgr_pkg and tbgr_in_if.
module tbgr_calc_pipe
(
    input  logic            clk,
    input  logic            rst_n,
    input  tbgr_pkg::cfg_t  cfg,
    tbgr_in_if.sink         samples,
    output logic            item_valid,
    output tbgr_pkg::item_t item,
    input  logic            take
);

    localparam int NUM_STAGES = 10;
    localparam int LAST       = NUM_STAGES - 1;
    localparam int W          = tbgr_pkg::SAMPLE_W;

    typedef struct packed {
        logic         black;
        logic         brake;
        logic [W-1:0] dev;
        logic [W-1:0] shreg;
        logic [W-1:0] rem;
        logic [W-1:0] quo;
        logic [W-1:0] step;
        logic [W-1:0] fulls;
    } calc_t;

    typedef struct packed {
        logic [W-1:0] rem;
        logic         q;
    } div_t;

    logic  [NUM_STAGES-1:0] valid_reg;
    logic  [NUM_STAGES-1:0] valid_next;
    calc_t                  stage_reg  [NUM_STAGES];
    calc_t                  stage_next [NUM_STAGES];
    logic                   en;
    logic  [W-1:0]          len_d;
    logic  [W+7:0]          num;

    // one restoring step: shift in a numerator bit, subtract if it fits
    function automatic div_t div_bit(input logic [W-1:0] rem, input logic nbit,
                                     input logic [W-1:0] d);
        div_t        r;
        logic [W:0]  t;
        t = {rem, nbit};
        if (t >= {1'b0, d})
        begin
            t   = t - {1'b0, d};
            r.q = 1'b1;
        end
        else
        begin
            r.q = 1'b0;
        end
        r.rem = t[W-1:0];
        return r;
    endfunction

    // four quotient bits per stage
    function automatic calc_t run4(input calc_t c_in, input logic [W-1:0] d);
        calc_t c;
        div_t  r;
        c = c_in;
        for (int j = 0; j < 4; j++)
        begin
            r       = div_bit(c.rem, c.shreg[W-1], d);
            c.rem   = r.rem;
            c.shreg = {c.shreg[W-2:0], 1'b0};
            c.quo   = {c.quo[W-2:0], r.q};
        end
        return c;
    endfunction

    assign en            = !valid_reg[LAST] || take;
    assign samples.ready = en;
    assign len_d         = W'(tbgr_pkg::clamp_len(cfg.strip_length));
    assign num           = {stage_reg[6].rem, 8'd0} - {8'd0, stage_reg[6].rem};

    always_comb
    begin
        // setup: deviation from center and span above center
        stage_next[0]       = '0;
        stage_next[0].black = !(samples.system_on && samples.bar_allowed);
        stage_next[0].brake = samples.throttle_sample < cfg.center_value;
        stage_next[0].dev   = stage_next[0].brake
                            ? cfg.center_value - samples.throttle_sample
                            : samples.throttle_sample - cfg.center_value;
        stage_next[0].shreg = (cfg.full_value > cfg.center_value)
                            ? cfg.full_value - cfg.center_value : '0;

        // span / length
        stage_next[1] = run4(stage_reg[0], len_d);
        stage_next[2] = run4(stage_reg[1], len_d);
        stage_next[3] = run4(stage_reg[2], len_d);

        // clamp zero step, then deviation / step
        stage_next[4]       = stage_reg[3];
        stage_next[4].step  = (stage_reg[3].quo == '0) ? W'(1) : stage_reg[3].quo;
        stage_next[4].shreg = stage_reg[3].dev;
        stage_next[4].rem   = '0;
        stage_next[4].quo   = '0;
        stage_next[4]       = run4(stage_next[4], stage_next[4].step);
        stage_next[5]       = run4(stage_reg[4], stage_reg[4].step);
        stage_next[6]       = run4(stage_reg[5], stage_reg[5].step);

        // 255 * remainder; its top bits are already below the step
        stage_next[7]       = stage_reg[6];
        stage_next[7].fulls = stage_reg[6].quo;
        stage_next[7].rem   = num[W+7:8];
        stage_next[7].shreg = {num[7:0], 4'd0};
        stage_next[7].quo   = '0;

        // partial level, eight quotient bits
        stage_next[8] = run4(stage_reg[7], stage_reg[7].step);
        stage_next[9] = run4(stage_reg[8], stage_reg[8].step);

        valid_next = {valid_reg[NUM_STAGES-2:0], samples.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign item_valid = valid_reg[LAST];
    assign item.black = stage_reg[LAST].black;
    assign item.brake = stage_reg[LAST].brake;
    assign item.fulls = stage_reg[LAST].fulls;
    assign item.part  = stage_reg[LAST].quo[tbgr_pkg::BYTE_W-1:0];

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && !take |=> valid_reg[LAST] && $stable(stage_reg[LAST]))
        else $error("final stage changed while stalled");

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> stage_reg[4].step != '0)
        else $error("zero step reached the divider");

    a_rem_below_step: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[6] |-> stage_reg[6].rem < stage_reg[6].step)
        else $error("remainder not below step");

endmodule

>>> hdl/tbgr_frame_emit.sv
// Frame emitter: registers one LED color per cycle unless the sink stalls.
// Depends on tbgr_pkg and tbgr_out_if.
module tbgr_frame_emit
(
    input  logic            clk,
    input  logic            rst_n,
    input  tbgr_pkg::cfg_t  cfg,
    input  logic            item_valid,
    input  tbgr_pkg::item_t item,
    output logic            take,
    tbgr_out_if.source      pixels
);

    localparam int CW = tbgr_pkg::CNT_W;
    localparam int BW = tbgr_pkg::BYTE_W;

    logic                          busy_reg,  busy_next;
    logic [CW-1:0]                 p_reg,     p_next;
    logic [CW-1:0]                 total_reg;
    tbgr_pkg::item_t               frame_reg;
    logic                          ov_reg,    ov_next;
    logic [tbgr_pkg::IDX_W-1:0]    idx_reg;
    logic [BW-1:0]                 b1_reg, b2_reg, b3_reg;
    logic                          fe_reg;

    logic [CW-1:0] len_eff;
    logic [CW-1:0] half;
    logic [CW-1:0] item_total;
    logic [CW-1:0] pos;
    logic [BW-1:0] lv;
    logic [BW-1:0] r, g, b;
    logic [BW-1:0] c1, c2, c3;
    logic          fire;
    logic          last;

    assign len_eff = tbgr_pkg::clamp_len(cfg.strip_length);
    assign half    = len_eff >> 1;

    always_comb
    begin
        if (item.black)
        begin
            item_total = CW'(tbgr_pkg::STRIP_LEDS);
        end
        else
        begin
            case (cfg.fill_mode) inside
                tbgr_pkg::FILL_BOTTOM, tbgr_pkg::FILL_TOP: item_total = len_eff;
                tbgr_pkg::FILL_MIDDLE:                     item_total = half << 1;
                default:                                   item_total = '0;
            endcase
        end
    end

    assign fire = busy_reg && (!ov_reg || pixels.ready);
    assign last = p_reg == total_reg - CW'(1);
    assign take = !busy_reg || (fire && last);

    // distance of this LED from the start of the bar
    always_comb
    begin
        case (cfg.fill_mode)
            tbgr_pkg::FILL_TOP:    pos = len_eff - CW'(1) - p_reg;
            tbgr_pkg::FILL_MIDDLE: pos = (p_reg < half) ? half - CW'(1) - p_reg
                                                        : p_reg - half;
            default:               pos = p_reg;
        endcase
    end

    always_comb
    begin
        if (frame_reg.black)
        begin
            lv = '0;
        end
        else if (tbgr_pkg::SAMPLE_W'(pos) < frame_reg.fulls)
        begin
            lv = '1;
        end
        else if (tbgr_pkg::SAMPLE_W'(pos) == frame_reg.fulls)
        begin
            lv = frame_reg.part;
        end
        else
        begin
            lv = '0;
        end
        r = (frame_reg.brake && !frame_reg.black) ? lv : '0;
        g = (frame_reg.brake && !frame_reg.black) ? '0 : lv;
        b = '0;
    end

    always_comb
    begin
        unique case (cfg.byte_order)
            tbgr_pkg::ORDER_RGB: begin c1 = r; c2 = g; c3 = b; end
            tbgr_pkg::ORDER_RBG: begin c1 = r; c2 = b; c3 = g; end
            tbgr_pkg::ORDER_GRB: begin c1 = g; c2 = r; c3 = b; end
            tbgr_pkg::ORDER_GBR: begin c1 = g; c2 = b; c3 = r; end
            tbgr_pkg::ORDER_BRG: begin c1 = b; c2 = r; c3 = g; end
            tbgr_pkg::ORDER_BGR: begin c1 = b; c2 = g; c3 = r; end
            default:             begin c1 = '0; c2 = '0; c3 = '0; end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        p_next    = p_reg;
        if (take)
        begin
            busy_next = item_valid && (item_total != '0);
            p_next    = '0;
        end
        else if (fire)
        begin
            p_next = p_reg + CW'(1);
        end

        ov_next = ov_reg;
        if (fire)
        begin
            ov_next = 1'b1;
        end
        else if (pixels.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            p_reg    <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            p_reg    <= p_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && item_valid)
        begin
            frame_reg <= item;
            total_reg <= item_total;
        end
        if (fire)
        begin
            idx_reg <= tbgr_pkg::IDX_W'(p_reg);
            b1_reg  <= c1;
            b2_reg  <= c2;
            b3_reg  <= c3;
            fe_reg  <= last;
        end
    end

    assign pixels.valid       = ov_reg;
    assign pixels.led_index   = idx_reg;
    assign pixels.first_byte  = b1_reg;
    assign pixels.second_byte = b2_reg;
    assign pixels.third_byte  = b3_reg;
    assign pixels.frame_end   = fe_reg;

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> p_reg < total_reg)
        else $error("LED counter ran past the frame");

    a_frame_end_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> ov_reg && fe_reg)
        else $error("last LED of a frame not flagged");

    a_black_full_strip: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && frame_reg.black |-> total_reg == CW'(tbgr_pkg::STRIP_LEDS))
        else $error("black frame does not cover the whole strip");

endmodule

>>> hdl/throttle_bar_graph_renderer_top.sv
// Throttle bar graph renderer: one throttle sample in, one frame of LED colors out.
// A sample passes the pipe stages, then the emitter's frame and output registers.
// Throughput: one LED color per cycle while the sink takes each color; a frame
// emits STRIP_LEDS colors when dark, the clamped strip length in bottom/top mode,
// 2*floor(length/2) in middle mode, else none; the single output port sets the rate.
// Reset (rst_n low, asynchronous) empties the pipe and loads the register defaults.
module throttle_bar_graph_renderer_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    tbgr_in_if.sink                         samples,
    tbgr_out_if.source                      pixels,
    input  logic                            cfg_we,
    input  logic [tbgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbgr_pkg::CFG_DATA_W-1:0] cfg_data
);

    tbgr_pkg::cfg_t  cfg_reg;
    tbgr_pkg::cfg_t  cfg_next;
    logic            item_valid;
    tbgr_pkg::item_t item;
    logic            take;

    // Register file. The user must make writes only while the block is idle; the block
    // does not enforce it. The arithmetic pipe and emitter read these fields directly.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tbgr_pkg::REG_CENTER_VALUE:
                    cfg_next.center_value = cfg_data[tbgr_pkg::SAMPLE_W-1:0];
                tbgr_pkg::REG_FULL_VALUE:
                    cfg_next.full_value   = cfg_data[tbgr_pkg::SAMPLE_W-1:0];
                tbgr_pkg::REG_STRIP_LENGTH:
                    cfg_next.strip_length = cfg_data[tbgr_pkg::LEN_W-1:0];
                tbgr_pkg::REG_FILL_MODE:
                    cfg_next.fill_mode    = cfg_data[1:0];
                tbgr_pkg::REG_BYTE_ORDER:
                    cfg_next.byte_order   = cfg_data[2:0];
                default:
                    cfg_next = cfg_reg;   // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_value <= tbgr_pkg::SAMPLE_W'(1500);
            cfg_reg.full_value   <= tbgr_pkg::SAMPLE_W'(2000);
            cfg_reg.strip_length <= tbgr_pkg::LEN_W'(32);
            cfg_reg.fill_mode    <= tbgr_pkg::FILL_BOTTOM;
            cfg_reg.byte_order   <= tbgr_pkg::ORDER_GRB;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Arithmetic pipe: accepts a sample transaction whenever its last stage
    // is empty or being handed to the emitter; every stage advances together.
    tbgr_calc_pipe u_calc
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .samples    (samples),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    // Emitter: takes the next frame in the cycle the current one issues its
    // last LED, so frames follow one another without a gap; the emitter stalls
    // while a registered color waits for the sink.
    tbgr_frame_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .pixels     (pixels)
    );

endmodule
